### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the parity recovery checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpr check failed");

// next-cycle implication
`define RPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpr check failed");

`endif

### hdl/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Constants, codes and shared types of the parity recovery unit.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam int MAX_DISKS      = 8;
    localparam int MAX_BLOCK_BITS = 32;

    localparam int ND_W    = 4;                     // num_disks register
    localparam int BB_W    = 6;                     // block_bits register
    localparam int DISK_W  = $clog2(MAX_DISKS);
    localparam int IDX_W   = $clog2(MAX_BLOCK_BITS);
    localparam int ADDR_W  = IDX_W + 1;             // bank bit on top
    localparam int NBITS_W = $clog2(MAX_DISKS * MAX_BLOCK_BITS + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DISKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD = 2'd2;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DRAIN,
        BS_PAD,
        BS_VERDICT
    } t_bstate;

    // one unit of back-end work, queued by the front end
    typedef struct packed {
        logic               drain;   // emit the finished block
        logic               bank;
        logic [DISK_W-1:0]  pdisk;   // parity disk of that block
        logic [ND_W-1:0]    ndisk;
        logic [BB_W-1:0]    bb;
        logic [NBITS_W-1:0] nbits;   // data bits in the block
        logic               fin;     // set end: pad and verdict
        logic               ok;      // verdict
    } t_cmd;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [MAX_DISKS-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic done;                  // drain of bank finished
        logic bank;
    } t_bk_status;

endpackage

### hdl/rpr_front.sv
// ----------------------------------------------------------------------------
// rpr_front
// Column intake: parity check, single erasure rebuild, block tracking and
// back-end command generation. Holds the configuration registers.
// ----------------------------------------------------------------------------
module rpr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rpr_pkg::MAX_DISKS-1:0]   i_disk_bits,
    input  logic [rpr_pkg::MAX_DISKS-1:0]   i_erased_mask,
    input  logic                            i_last_in_set,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rpr_pkg::t_wr_req                o_wr,
    output logic                            o_push,
    output rpr_pkg::t_cmd                   o_cmd,
    input  logic                            i_fifo_full,
    input  rpr_pkg::t_bk_status             i_bk
);
    import rpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_DISKS + 1);

    function automatic logic [CNT_W-1:0] f_ones(input logic [MAX_DISKS-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_DISKS; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

    logic [ND_W-1:0]      r_num_disks;
    logic [BB_W-1:0]      r_block_bits;
    logic                 r_parity_odd;

    logic [IDX_W-1:0]     r_col_idx, n_col_idx;
    logic [DISK_W-1:0]    r_pdisk, n_pdisk;
    logic                 r_set_inv, n_set_inv;
    logic                 r_bank, n_bank;
    logic [1:0]           r_busy, n_busy;

    logic [ND_W-1:0]      d;
    logic [BB_W-1:0]      bb;
    logic [MAX_DISKS-1:0] dmask, bits, er, known, col;
    logic [CNT_W-1:0]     ne;
    logic                 par, bad, fix, inv_now;
    logic [BB_W-1:0]      idx_p1;
    logic                 complete, drain, accept;
    logic [ND_W-1:0]      p_inc, nd;
    logic [DISK_W-1:0]    p_rot;
    logic [NBITS_W-1:0]   nbits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_disks  <= ND_W'(2);
            r_block_bits <= BB_W'(1);
            r_parity_odd <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_DISKS:  r_num_disks  <= i_cfg_data[ND_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BB_W-1:0];
                CFG_PARITY_ODD: r_parity_odd <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturated register views
    always_comb begin
        d = r_num_disks;
        if (r_num_disks < ND_W'(2)) begin
            d = ND_W'(2);
        end else if (r_num_disks > ND_W'(MAX_DISKS)) begin
            d = ND_W'(MAX_DISKS);
        end
        bb = r_block_bits;
        if (r_block_bits == '0) begin
            bb = BB_W'(1);
        end else if (r_block_bits > BB_W'(MAX_BLOCK_BITS)) begin
            bb = BB_W'(MAX_BLOCK_BITS);
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_DISKS; k++) begin
            dmask[k] = (ND_W'(k) < d);
        end
        bits  = i_disk_bits & dmask;
        er    = i_erased_mask & dmask;
        known = bits & ~er;
        ne    = f_ones(er);
        par   = ^known;
        bad   = 1'b0;
        fix   = 1'b0;
        // once invalid, columns go unchecked
        if (!r_set_inv) begin
            if (ne >= CNT_W'(2)) begin
                bad = 1'b1;
            end else if (ne == '0) begin
                bad = (par != r_parity_odd);
            end else begin
                fix = par ^ r_parity_odd;
            end
        end
        col     = fix ? (known | er) : known;
        inv_now = r_set_inv | bad;

        idx_p1   = BB_W'(r_col_idx) + BB_W'(1);
        complete = (idx_p1 >= bb);
        drain    = complete & ~inv_now;

        p_inc = ND_W'(r_pdisk) + ND_W'(1);
        p_rot = (p_inc >= d) ? '0 : p_inc[DISK_W-1:0];
        // parity disk left beyond the disk count skips nothing
        nd    = (ND_W'(r_pdisk) < d) ? (d - ND_W'(1)) : d;
        nbits = NBITS_W'(nd) * NBITS_W'(bb);
    end

    assign o_stall = r_busy[r_bank] | i_fifo_full;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        n_col_idx = r_col_idx;
        n_pdisk   = r_pdisk;
        n_set_inv = r_set_inv;
        n_bank    = r_bank;
        n_busy    = r_busy;
        if (i_bk.done) begin
            n_busy[i_bk.bank] = 1'b0;
        end
        if (accept) begin
            n_set_inv = inv_now;
            if (complete) begin
                n_col_idx = '0;
                n_pdisk   = p_rot;
            end else begin
                n_col_idx = idx_p1[IDX_W-1:0];
            end
            if (drain) begin
                n_busy[r_bank] = 1'b1;
                n_bank         = ~r_bank;
            end
            if (i_last_in_set) begin
                n_col_idx = '0;
                n_pdisk   = '0;
                n_set_inv = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx <= '0;
            r_pdisk   <= '0;
            r_set_inv <= 1'b0;
            r_bank    <= 1'b0;
            r_busy    <= '0;
        end else begin
            r_col_idx <= n_col_idx;
            r_pdisk   <= n_pdisk;
            r_set_inv <= n_set_inv;
            r_bank    <= n_bank;
            r_busy    <= n_busy;
        end
    end

    always_comb begin
        o_wr.en   = accept;
        o_wr.addr = {r_bank, r_col_idx};
        o_wr.data = col;

        o_push      = accept & (drain | i_last_in_set);
        o_cmd.drain = drain;
        o_cmd.bank  = r_bank;
        o_cmd.pdisk = r_pdisk;
        o_cmd.ndisk = d;
        o_cmd.bb    = bb;
        o_cmd.nbits = nbits;
        o_cmd.fin   = i_last_in_set;
        o_cmd.ok    = ~inv_now;
    end

endmodule

### hdl/rpr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rpr_cmd_fifo
// Short command queue between the column front end and the drain back end.
// ----------------------------------------------------------------------------
module rpr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output rpr_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import rpr_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/rpr_back.sv
// ----------------------------------------------------------------------------
// rpr_back
// Block store and drain sequencer: reads finished blocks disk by disk,
// packs bits into nibbles, pads at set end and issues the verdict.
// ----------------------------------------------------------------------------
module rpr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rpr_pkg::t_wr_req       i_wr,
    input  rpr_pkg::t_cmd          i_cmd,
    input  logic                   i_empty,
    output logic                   o_pop,
    output rpr_pkg::t_bk_status    o_bk,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_kind,
    output logic [3:0]             o_nibble,
    output logic                   o_set_valid,
    output logic                   o_last
);
    import rpr_pkg::*;

    // two banks: one fills while the other drains
    logic [MAX_DISKS-1:0] r_store [2 * MAX_BLOCK_BITS];
    logic [MAX_DISKS-1:0] r_rd_data;

    t_bstate              r_state, n_state;
    t_cmd                 r_cmd;
    logic [ND_W-1:0]      r_k;
    logic [IDX_W-1:0]     r_j;
    logic [NBITS_W-1:0]   r_left;
    logic                 r_bv;
    logic [DISK_W-1:0]    r_bk;
    logic                 r_blast;
    logic [3:0]           r_acc;
    logic [1:0]           r_cnt;

    logic                 r_ovalid, r_okind, r_oset_valid, r_olast;
    logic [3:0]           r_onib;

    logic                 out_free, b_full, b_adv, issue, cur_bit;
    logic [BB_W-1:0]      j_p1;
    logic                 wrap;
    logic [ND_W-1:0]      k_p1, k_nx;
    logic                 pad_need, drained;
    logic                 ld_nib, ld_pad, ld_ver;
    logic [3:0]           pad_nib;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_store[{r_cmd.bank, r_j}];
        end
    end

    always_comb begin
        out_free = ~r_ovalid | ~i_stall;
        b_full   = (r_cnt == 2'd3);
        b_adv    = r_bv & (~b_full | out_free);
        issue    = (r_state == BS_DRAIN) && (r_left != '0) && (~r_bv || b_adv);
        cur_bit  = r_rd_data[r_bk];

        j_p1 = BB_W'(r_j) + BB_W'(1);
        wrap = (j_p1 == r_cmd.bb);
        k_p1 = r_k + ND_W'(1);
        k_nx = (k_p1 == ND_W'(r_cmd.pdisk)) ? (r_k + ND_W'(2)) : k_p1;

        pad_need = r_cmd.ok & (r_cnt != 2'd0);
        drained  = (r_left == '0) & ~r_bv;

        case (r_cnt)
            2'd1:    pad_nib = {r_acc[0], 3'b000};
            2'd2:    pad_nib = {r_acc[1:0], 2'b00};
            2'd3:    pad_nib = {r_acc[2:0], 1'b0};
            default: pad_nib = r_acc;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) n_state = BS_DRAIN;
            end
            BS_DRAIN: begin
                if (drained) n_state = r_cmd.fin ? BS_PAD : BS_IDLE;
            end
            BS_PAD: begin
                if (!pad_need || out_free) n_state = BS_VERDICT;
            end
            BS_VERDICT: begin
                if (out_free) n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop     = 1'b0;
        o_bk.done = 1'b0;
        o_bk.bank = r_cmd.bank;
        ld_pad    = 1'b0;
        ld_ver    = 1'b0;
        unique case (r_state)
            BS_IDLE:    o_pop     = ~i_empty;
            BS_DRAIN:   o_bk.done = drained & r_cmd.drain;
            BS_PAD:     ld_pad    = pad_need & out_free;
            BS_VERDICT: ld_ver    = out_free;
            default: ;
        endcase
        ld_nib = b_adv & b_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_bv     <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_bv <= 1'b1;
            end else if (b_adv) begin
                r_bv <= 1'b0;
            end
            if (b_adv) begin
                r_acc <= {r_acc[2:0], cur_bit};
                r_cnt <= r_cnt + 2'd1;
            end else if (ld_pad || ld_ver) begin
                r_acc <= '0;
                r_cnt <= '0;
            end
            if (ld_nib || ld_pad || ld_ver) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // drain position and command payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_j    <= '0;
            r_k    <= (i_cmd.pdisk == '0) ? ND_W'(1) : '0;
            r_left <= i_cmd.drain ? i_cmd.nbits : '0;
        end else if (issue) begin
            r_left <= r_left - NBITS_W'(1);
            if (wrap) begin
                r_j <= '0;
                r_k <= k_nx;
            end else begin
                r_j <= j_p1[IDX_W-1:0];
            end
        end
        if (issue) begin
            r_bk    <= r_k[DISK_W-1:0];
            // fewer than four bits follow: no further nibble in this block
            r_blast <= (r_left <= NBITS_W'(4));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_nib) begin
            r_okind      <= KIND_DATA;
            r_onib       <= {r_acc[2:0], cur_bit};
            r_oset_valid <= 1'b0;
            r_olast      <= r_blast & ~r_cmd.fin;
        end else if (ld_pad) begin
            r_okind      <= KIND_DATA;
            r_onib       <= pad_nib;
            r_oset_valid <= 1'b0;
            r_olast      <= 1'b0;
        end else if (ld_ver) begin
            r_okind      <= KIND_VERDICT;
            r_onib       <= '0;
            r_oset_valid <= r_cmd.ok;
            r_olast      <= 1'b1;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_kind      = r_okind;
    assign o_nibble    = r_onib;
    assign o_set_valid = r_oset_valid;
    assign o_last      = r_olast;

endmodule

### hdl/raid_parity_recover_unit.sv
// ----------------------------------------------------------------------------
// raid_parity_recover_unit
// Rotating-parity single erasure recovery with nibble output and set verdict.
// ----------------------------------------------------------------------------
// Columns are taken at one per cycle unless stalled and written into a two-bank
// block store; each finished block is then read back disk by disk through the
// store's one read port at one bit per cycle while the output is not stalled,
// so a block yields (num_disks-1)*block_bits bits (num_disks*block_bits when
// the parity disk sits beyond the disk count). A set end adds the pad nibble,
// when one is due, and the verdict. Input stalls while the bank to be filled is
// still draining or the two-entry command queue is full. Data nibbles of a set
// come out before its verdict: drop them when the verdict has set_valid low.
// Configuration writes are taken every cycle and belong between sets while the
// unit is idle.
module raid_parity_recover_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_disk_bits,
    input  logic [7:0]                      i_erased_mask,
    input  logic                            i_last_in_set,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_kind,
    output logic [3:0]                      o_nibble,
    output logic                            o_set_valid,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rpr_pkg::*;

    t_wr_req    wr;
    t_cmd       push_cmd, head_cmd;
    t_bk_status bk;
    logic       push, pop, full, empty;

    rpr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_disk_bits   (i_disk_bits),
        .i_erased_mask (i_erased_mask),
        .i_last_in_set (i_last_in_set),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_wr          (wr),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_fifo_full   (full),
        .i_bk          (bk)
    );

    rpr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    rpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_bk        (bk),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_nibble    (o_nibble),
        .o_set_valid (o_set_valid),
        .o_last      (o_last)
    );

endmodule

### hdl/rpr_checker.sv
// ----------------------------------------------------------------------------
// rpr_checker
// Port-level checks on the result stream of the parity recovery unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_kind,
    input logic [3:0]                      o_nibble,
    input logic                            o_set_valid,
    input logic                            o_last
);
    import rpr_pkg::*;

    // a verdict closes the results of its set
    `RPR_ASSERT_IMP(a_verdict_last, i_clk, i_rst_n, o_valid && o_kind == KIND_VERDICT, o_last)

    `RPR_ASSERT_IMP(a_verdict_zero, i_clk, i_rst_n, o_valid && o_kind == KIND_VERDICT, o_nibble == 4'd0)

    `RPR_ASSERT_IMP(a_data_no_flag, i_clk, i_rst_n, o_valid && o_kind == KIND_DATA, !o_set_valid)

    `RPR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_nibble) && $stable(o_kind) && $stable(o_last))

endmodule

bind raid_parity_recover_unit rpr_checker u_rpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_nibble      (o_nibble),
    .o_set_valid   (o_set_valid),
    .o_last        (o_last)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: raid_parity_recover_unit
// Self-checking bench. Columns go in through a directed table and then through
// random disk sets. Each accepted column runs through a local predictor of the
// parity check, single-erasure rebuild, rotating-parity unload and nibble
// packing. Every nibble and verdict is then compared in order with the
// expected one. Sender gaps, receiver stalls and one long receiver hold-off
// are mixed in by phase.
// ----------------------------------------------------------------------------
module tb;
    import rpr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 400;   // > longest block unload (8 disks x 32 bits)
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_COLS   = 6;
    localparam int NUM_PHASES   = 8;

    typedef struct packed {
        logic       kind;
        logic [3:0] nibble;
        logic       set_valid;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [7:0]            bits;
        logic [7:0]            erased;
        logic                  fin;
        logic [1:0]            n_typed;
        out_word_t             typed_a;
        out_word_t             typed_b;
    } dir_row_t;

    localparam out_word_t NO_WORD     = '0;
    localparam out_word_t NIB_1000    = '{KIND_DATA, 4'b1000, 1'b0, 1'b0};
    localparam out_word_t NIB_0000    = '{KIND_DATA, 4'b0000, 1'b0, 1'b0};
    localparam out_word_t VERDICT_OK  = '{KIND_VERDICT, 4'b0000, 1'b1, 1'b1};
    localparam out_word_t VERDICT_BAD = '{KIND_VERDICT, 4'b0000, 1'b0, 1'b1};

    localparam int DIR_ROWS = 38;
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        // defaults after reset: 2 disks, 1-bit blocks, even parity
        '{1'b0, '0, 6'd0, 8'h03, 8'h00, 1'b1, 2'd2, NIB_1000, VERDICT_OK},
        '{1'b0, '0, 6'd0, 8'h01, 8'h00, 1'b1, 2'd1, VERDICT_BAD, NO_WORD},  // parity off
        '{1'b0, '0, 6'd0, 8'h00, 8'h03, 1'b1, 2'd1, VERDICT_BAD, NO_WORD},  // two erased
        '{1'b0, '0, 6'd0, 8'hFC, 8'h00, 1'b1, 2'd2, NIB_0000, VERDICT_OK},  // upper disks
        '{1'b0, '0, 6'd0, 8'h01, 8'hFE, 1'b1, 2'd2, NIB_1000, VERDICT_OK},  // rebuild disk 1
        '{1'b1, CFG_PARITY_ODD, 6'd1, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h00, 8'h00, 1'b1, 2'd1, VERDICT_BAD, NO_WORD},
        '{1'b1, CFG_NUM_DISKS, 6'd8, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_BLOCK_BITS, 6'd2, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h07, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h00, 8'h10, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'hFE, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h7F, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h01, 8'h00, 1'b1, 2'd0, NO_WORD, NO_WORD},  // ends mid-block
        // set goes bad on its first column, rest is ignored
        '{1'b0, '0, 6'd0, 8'h00, 8'h03, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h55, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'hFF, 8'h00, 1'b1, 2'd0, NO_WORD, NO_WORD},
        // out-of-range register values saturate
        '{1'b1, CFG_NUM_DISKS, 6'h3F, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_BLOCK_BITS, 6'd0, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h02, 8'h80, 1'b1, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_NUM_DISKS, 6'd1, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_BLOCK_BITS, 6'd40, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h01, 8'h00, 1'b1, 2'd0, NO_WORD, NO_WORD},
        // disk count drops mid-set below the current parity disk
        '{1'b1, CFG_NUM_DISKS, 6'd8, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_BLOCK_BITS, 6'd1, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_PARITY_ODD, 6'd0, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h03, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h03, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_NUM_DISKS, 6'd3, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h05, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h06, 8'h00, 1'b1, 2'd0, NO_WORD, NO_WORD},
        // block size shrinks below the column count of the open block
        '{1'b1, CFG_BLOCK_BITS, 6'd4, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h03, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h05, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h06, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b1, CFG_BLOCK_BITS, 6'd2, 8'h00, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{1'b0, '0, 6'd0, 8'h00, 8'h00, 1'b1, 2'd0, NO_WORD, NO_WORD}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_disk_bits = '0;
    logic [7:0]            i_erased_mask = '0;
    logic                  i_last_in_set = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_kind;
    logic [3:0]            o_nibble;
    logic                  o_set_valid;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // typed-in expectations travel with the request they belong to
    logic [1:0] row_words = 2'd0;
    out_word_t  row_word_a = '0;
    out_word_t  row_word_b = '0;

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    int unsigned cols_sent = 0;
    int unsigned cycle_cnt = 0;
    int unsigned errs = 0;

    // predictor state
    logic [3:0]  rg_disks = 4'd2;
    logic [5:0]  rg_bb = 6'd1;
    logic        rg_odd = 1'b0;
    logic [7:0]  col_mem [MAX_BLOCK_BITS];
    int unsigned col_pos = 0;
    int unsigned pdisk = 0;
    bit          set_bad = 1'b0;
    logic [3:0]  nib_acc = '0;
    int unsigned nib_fill = 0;
    out_word_t   col_words [$];
    out_word_t   recovered_q [$];

    raid_parity_recover_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_disk_bits   (i_disk_bits),
        .i_erased_mask (i_erased_mask),
        .i_last_in_set (i_last_in_set),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_nibble      (o_nibble),
        .o_set_valid   (o_set_valid),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void shift_bit(logic b);
        nib_acc = {nib_acc[2:0], b};
        nib_fill++;
        if (nib_fill == 4) begin
            col_words.push_back(out_word_t'{KIND_DATA, nib_acc, 1'b0, 1'b0});
            nib_acc = '0;
            nib_fill = 0;
        end
    endfunction

    // one column in, nibbles and verdict of this column into col_words
    function automatic void recover_column(logic [7:0] bits, logic [7:0] mask, logic fin);
        int unsigned nd, nb, pos, k, j;
        logic [7:0]  dmask, known, er, colv;
        logic        par;
        nd = (rg_disks < 2) ? 2 : (rg_disks > MAX_DISKS) ? MAX_DISKS : rg_disks;
        nb = (rg_bb < 1) ? 1 : (rg_bb > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : rg_bb;
        dmask = 8'((1 << nd) - 1);
        known = bits & ~mask & dmask;
        er = mask & dmask;
        colv = known;
        col_words.delete();
        if (!set_bad) begin
            par = ^known;
            if ($countones(er) >= 2) set_bad = 1'b1;
            else if (er == 8'h00) begin
                if (par != rg_odd) set_bad = 1'b1;
            end else if (par != rg_odd) colv = known | er;
        end
        pos = (col_pos >= MAX_BLOCK_BITS) ? MAX_BLOCK_BITS - 1 : col_pos;
        col_mem[pos] = colv;
        if (col_pos + 1 >= nb) begin
            if (!set_bad) begin
                // a parity disk beyond the disk count skips nothing
                for (k = 0; k < nd; k++)
                    if (k != pdisk)
                        for (j = 0; j < nb; j++) shift_bit(col_mem[j][k]);
            end
            pdisk++;
            if (pdisk >= nd) pdisk = 0;
            col_pos = 0;
        end else begin
            col_pos++;
        end
        if (fin) begin
            if (!set_bad)
                while (nib_fill != 0) shift_bit(1'b0);
            col_words.push_back(out_word_t'{KIND_VERDICT, 4'd0, !set_bad, 1'b0});
            col_pos = 0;
            pdisk = 0;
            set_bad = 1'b0;
            nib_acc = '0;
            nib_fill = 0;
        end
        if (col_words.size() != 0) col_words[col_words.size() - 1].last = 1'b1;
    endfunction

    // request monitor, predictor and result check
    always @(posedge i_clk) begin
        out_word_t want, got;
        if (!i_rst_n) begin
            rg_disks = 4'd2;
            rg_bb = 6'd1;
            rg_odd = 1'b0;
            col_pos = 0;
            pdisk = 0;
            set_bad = 1'b0;
            nib_acc = '0;
            nib_fill = 0;
            recovered_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_DISKS:  rg_disks = i_cfg_data[3:0];
                    CFG_BLOCK_BITS: rg_bb = i_cfg_data;
                    CFG_PARITY_ODD: rg_odd = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                recover_column(i_disk_bits, i_erased_mask, i_last_in_set);
                if (row_words != 2'd0) begin
                    recovered_q.push_back(row_word_a);
                    if (row_words == 2'd2) recovered_q.push_back(row_word_b);
                end else begin
                    foreach (col_words[i]) recovered_q.push_back(col_words[i]);
                end
            end
            if (o_valid && !i_stall) begin
                got = out_word_t'{o_kind, o_nibble, o_set_valid, o_last};
                if (recovered_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d nibble=%h set_valid=%0d last=%0d",
                             $time, got.kind, got.nibble, got.set_valid, got.last);
                    errs++;
                end else begin
                    want = recovered_q.pop_front();
                    if (got != want) begin
                        $display({"%0t: mismatch expected kind=%0d nibble=%h set_valid=%0d ",
                                  "last=%0d, got kind=%0d nibble=%h set_valid=%0d last=%0d"},
                                 $time, want.kind, want.nibble, want.set_valid, want.last,
                                 got.kind, got.nibble, got.set_valid, got.last);
                        errs++;
                    end
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_col(logic [7:0] bits, logic [7:0] mask, logic fin,
                            logic [1:0] tn, out_word_t tw_a, out_word_t tw_b);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_disk_bits <= bits;
        i_erased_mask <= mask;
        i_last_in_set <= fin;
        row_words <= tn;
        row_word_a <= tw_a;
        row_word_b <= tw_b;
        do @(posedge i_clk); while (o_stall);
        cols_sent++;
    endtask

    task automatic drain_wait();
        @(posedge i_clk);
        while (recovered_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] ra, logic [CFG_DATA_W-1:0] rv);
        i_valid <= 1'b0;
        drain_wait();
        // a column that completes nothing visible may still be unloading
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ra;
        i_cfg_data <= rv;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // one disk set: mostly clean columns, some with a single broken column, some noise
    task automatic send_set(int unsigned nd, int unsigned nb, logic odd);
        int unsigned ncols, c, bad_at, style, a, b;
        logic [7:0]  bits, mask, dmask;
        style = $urandom_range(99);
        ncols = $urandom_range(1, (nb == MAX_BLOCK_BITS) ? 1 : 3) * nb;
        if ($urandom_range(3) == 0) ncols += $urandom_range(0, nb - 1);
        bad_at = $urandom_range(0, ncols - 1);
        dmask = 8'((1 << nd) - 1);
        for (c = 0; c < ncols; c++) begin
            bits = 8'($urandom);
            mask = 8'($urandom);
            a = $urandom_range(0, nd - 1);
            if (style < 90 && !(style >= 75 && c == bad_at)) begin
                mask &= ~dmask;
                if ($urandom_range(2) == 0) mask[a] = 1'b1;
                else if ((^(bits & dmask)) != odd) bits[a] = ~bits[a];
            end else if (style < 90) begin
                if ($urandom_range(1) == 1) begin
                    b = (a + $urandom_range(1, nd - 1)) % nd;
                    mask[a] = 1'b1;
                    mask[b] = 1'b1;
                end else begin
                    mask &= ~dmask;
                    if ((^(bits & dmask)) == odd) bits[a] = ~bits[a];
                end
            end
            send_col(bits, mask, c == ncols - 1, 2'd0, NO_WORD, NO_WORD);
        end
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timeout", $time);
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned p, first, nd_eff, nb_eff;
        logic [5:0]  nd_raw, bb_raw;
        logic        odd;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[r]) begin
            if (DIR_TAB[r].is_reg)
                write_reg(DIR_TAB[r].reg_idx, DIR_TAB[r].reg_val);
            else
                send_col(DIR_TAB[r].bits, DIR_TAB[r].erased, DIR_TAB[r].fin,
                         DIR_TAB[r].n_typed, DIR_TAB[r].typed_a, DIR_TAB[r].typed_b);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 69; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 69; end
                default: begin gap_pct = 13; stall_pct = 13; end
            endcase
            nd_raw = 6'($urandom_range(2, MAX_DISKS));
            bb_raw = 6'($urandom_range(1, 6));
            odd = 1'($urandom_range(1));
            if (p == 1) begin
                nd_raw = 6'(MAX_DISKS);
                bb_raw = 6'(MAX_BLOCK_BITS);
            end else if (p == 2) begin
                // every column finishes a block of many bits: both banks back up fast
                nd_raw = 6'(MAX_DISKS);
                bb_raw = 6'd1;
            end else if (p == 3) begin
                nd_raw = 6'd2;
                bb_raw = 6'd1;
            end else if (p == 6) begin
                nd_raw = {2'($urandom), ($urandom_range(1) == 1) ?
                          4'($urandom_range(0, 1)) : 4'($urandom_range(9, 15))};
                bb_raw = ($urandom_range(1) == 1) ? 6'd0 : 6'($urandom_range(33, 63));
            end
            nd_eff = (nd_raw[3:0] < 2) ? 2 :
                     (nd_raw[3:0] > MAX_DISKS) ? MAX_DISKS : nd_raw[3:0];
            nb_eff = (bb_raw < 1) ? 1 : (bb_raw > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : bb_raw;
            write_reg(CFG_NUM_DISKS, nd_raw);
            write_reg(CFG_BLOCK_BITS, bb_raw);
            write_reg(CFG_PARITY_ODD, {5'd0, odd});
            // long receiver hold-off while requests keep coming: back-pressure reaches the input
            if (p == 2) hold_req++;
            first = cols_sent;
            while (cols_sent - first < PHASE_COLS) begin
                send_set(nd_eff, nb_eff, odd);
                if (p == 5) begin
                    i_valid <= 1'b0;
                    drain_wait();
                end
            end
        end

        i_valid <= 1'b0;
        drain_wait();
        repeat (SETTLE) @(posedge i_clk);
        if (errs == 0 && recovered_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/rpr_pkg.sv
hdl/rpr_front.sv
hdl/rpr_cmd_fifo.sv
hdl/rpr_back.sv
hdl/raid_parity_recover_unit.sv
hdl/rpr_checker.sv
sim/tb.sv
